FILE: hdl/udf_pkg.sv
// Package for the UTF-8 decode and fold block: payload types, limits, fold function.
// No dependencies.
package udf_pkg;

   localparam int unsigned MaxTextCodePoints = 1024;
   localparam int unsigned CountWidth = 11;
   localparam logic [10:0] MaxCodePointsReset = 11'd1024;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [20:0] folded_code_point;
      logic        has_code_point;
      logic        text_end;
      logic        text_rejected;
      logic [10:0] code_point_total;
   } rsp_type;

   // Latin Extended-A: lower, then strip to the base letter
   function automatic logic [20:0] ext_a_fold(input logic [20:0] c);
      logic        even_cap;
      logic        odd_cap;
      logic [20:0] l;
      logic [20:0] r;
      even_cap = (c <= 21'h137) || (c >= 21'h14A && c <= 21'h177);
      odd_cap  = (c >= 21'h139 && c <= 21'h148) || (c >= 21'h179 && c <= 21'h17E);
      l = c;
      if ((even_cap && !c[0]) || (odd_cap && c[0])) l = c + 21'd1;
      r = l;
      if (l == 21'h101 || l == 21'h103 || l == 21'h105) r = 21'h61;
      else if (l >= 21'h107 && l <= 21'h10D && l[0]) r = 21'h63;
      else if (l == 21'h10F || l == 21'h111) r = 21'h64;
      else if (l >= 21'h113 && l <= 21'h11B && l[0]) r = 21'h65;
      else if (l >= 21'h11D && l <= 21'h123 && l[0]) r = 21'h67;
      else if (l == 21'h125 || l == 21'h127) r = 21'h68;
      else if (l >= 21'h129 && l <= 21'h131 && l[0]) r = 21'h69;
      else if (l == 21'h135) r = 21'h6A;
      else if (l == 21'h137 || l == 21'h138) r = 21'h6B;
      else if (l >= 21'h13A && l <= 21'h142 && !l[0]) r = 21'h6C;
      else if (l == 21'h144 || l == 21'h146 || l == 21'h148 || l == 21'h149 ||
               l == 21'h14B) r = 21'h6E;
      else if (l == 21'h14D || l == 21'h14F || l == 21'h151) r = 21'h6F;
      else if (l == 21'h155 || l == 21'h157 || l == 21'h159) r = 21'h72;
      else if (l >= 21'h15B && l <= 21'h161 && l[0]) r = 21'h73;
      else if (l == 21'h163 || l == 21'h165 || l == 21'h167) r = 21'h74;
      else if (l >= 21'h169 && l <= 21'h173 && l[0]) r = 21'h75;
      else if (l == 21'h175) r = 21'h77;
      else if (l == 21'h177 || l == 21'h178) r = 21'h79;
      else if (l == 21'h17A || l == 21'h17C || l == 21'h17E) r = 21'h7A;
      return r;
   endfunction

   function automatic logic [20:0] greek_fold(input logic [20:0] c);
      logic [20:0] l;
      logic [20:0] r;
      case (c)
         21'h386: l = 21'h3AC;
         21'h388: l = 21'h3AD;
         21'h389: l = 21'h3AE;
         21'h38A: l = 21'h3AF;
         21'h38C: l = 21'h3CC;
         21'h38E: l = 21'h3CD;
         21'h38F: l = 21'h3CE;
         21'h3AA: l = 21'h3CA;
         21'h3AB: l = 21'h3CB;
         default: begin
            if (c >= 21'h391 && c <= 21'h3A9 && c != 21'h3A2) l = c + 21'h20;
            else l = c;
         end
      endcase
      case (l)
         21'h3AC: r = 21'h3B1;
         21'h3AD: r = 21'h3B5;
         21'h3AE: r = 21'h3B7;
         21'h390, 21'h3AF, 21'h3CA: r = 21'h3B9;
         21'h3CC: r = 21'h3BF;
         21'h3B0, 21'h3CB, 21'h3CD: r = 21'h3C5;
         21'h3CE: r = 21'h3C9;
         21'h3C2: r = 21'h3C3;
         default: r = l;
      endcase
      return r;
   endfunction

   function automatic logic [20:0] cyrillic_fold(input logic [20:0] c);
      logic [20:0] l;
      l = c;
      if (c >= 21'h400 && c <= 21'h40F) l = c + 21'h50;
      else if (c >= 21'h410 && c <= 21'h42F) l = c + 21'h20;
      else if (c == 21'h4C0) l = 21'h4CF;
      else if (c >= 21'h4C1 && c <= 21'h4CE) l = c[0] ? c + 21'd1 : c;
      else if ((c >= 21'h460 && c <= 21'h481) || (c >= 21'h48A && c <= 21'h4BF) ||
               (c >= 21'h4D0 && c <= 21'h4FF)) l = c[0] ? c : c + 21'd1;
      if (l == 21'h450 || l == 21'h451) return 21'h435;
      if (l == 21'h45D) return 21'h438;
      return l;
   endfunction

   function automatic logic [20:0] fold(input logic [20:0] cin);
      logic [20:0] c;
      c = cin;
      if (c < 21'h80) return (c >= 21'h41 && c <= 21'h5A) ? c + 21'h20 : c;
      if (c >= 21'hC0 && c <= 21'hDE && c != 21'hD7) c = c + 21'h20;
      if (c >= 21'hE0 && c <= 21'hE5) return 21'h61;
      if (c == 21'hE7) return 21'h63;
      if (c >= 21'hE8 && c <= 21'hEB) return 21'h65;
      if (c >= 21'hEC && c <= 21'hEF) return 21'h69;
      if (c == 21'hF1) return 21'h6E;
      if ((c >= 21'hF2 && c <= 21'hF6) || c == 21'hF8) return 21'h6F;
      if (c >= 21'hF9 && c <= 21'hFC) return 21'h75;
      if (c == 21'hFD || c == 21'hFF) return 21'h79;
      if (c >= 21'h100 && c <= 21'h17F) return ext_a_fold(c);
      if (c == 21'h218 || c == 21'h219) return 21'h73;
      if (c == 21'h21A || c == 21'h21B) return 21'h74;
      if (c >= 21'h370 && c <= 21'h3FF) return greek_fold(c);
      if (c >= 21'h400 && c <= 21'h4FF) return cyrillic_fold(c);
      if (c >= 21'h531 && c <= 21'h556) return c + 21'h30;
      if ((c >= 21'h1C90 && c <= 21'h1CBA) || (c >= 21'h1CBD && c <= 21'h1CBF))
         return c - 21'hBC0;
      return c;
   endfunction

endpackage

FILE: hdl/udf_decode.sv
// Decode stage: UTF-8 sequence state, error checks, code point count.
// Depends on udf_pkg. Produces an unfolded result for each accepted byte that ends a code point or the text.
module udf_decode #(
   parameter int unsigned MAX_TEXT_CODE_POINTS = udf_pkg::MaxTextCodePoints
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  udf_pkg::req_type    req,
   input  logic [10:0]         limit_reg,
   output logic                emit,
   output logic                done,
   output logic [20:0]         code_point,
   output logic                rejected,
   output logic [10:0]         total
);
   localparam int unsigned CntW = $clog2(MAX_TEXT_CODE_POINTS + 1) > 11 ?
                                  $clog2(MAX_TEXT_CODE_POINTS + 1) : 11;
   localparam logic [CntW-1:0] ParamLimit = CntW'(MAX_TEXT_CODE_POINTS);

   logic [20:0]     pending_ff, pending_in;
   logic [1:0]      remain_ff, remain_in;
   logic [1:0]      seqlen_ff, seqlen_in;
   logic [CntW-1:0] count_ff, count_in;
   logic            reject_ff, reject_in;

   logic [CntW-1:0] reg_ext, limit;
   logic [7:0]      b;
   logic            last, err;
   logic [20:0]     shifted, least;

   always_comb begin
      b = req.data_byte;
      last = req.end_of_text;
      reg_ext = CntW'(limit_reg);
      limit = (reg_ext < ParamLimit) ? reg_ext : ParamLimit;
      pending_in = pending_ff;
      remain_in = remain_ff;
      seqlen_in = seqlen_ff;
      err = 1'b0;
      done = 1'b0;
      code_point = '0;
      shifted = {pending_ff[14:0], b[5:0]};
      case (seqlen_ff)
         2'd1:    least = 21'h80;
         2'd2:    least = 21'h800;
         default: least = 21'h10000;
      endcase
      if (!reject_ff) begin
         if (remain_ff == 2'd0) begin
            if (count_ff >= limit) err = 1'b1;
            else if (!b[7]) begin
               code_point = {13'd0, b};
               done = 1'b1;
            end else begin
               if (b[7:5] == 3'b110) begin
                  seqlen_in = 2'd1; pending_in = {16'd0, b[4:0]};
               end else if (b[7:4] == 4'b1110) begin
                  seqlen_in = 2'd2; pending_in = {17'd0, b[3:0]};
               end else if (b[7:3] == 5'b11110) begin
                  seqlen_in = 2'd3; pending_in = {18'd0, b[2:0]};
               end else err = 1'b1;
               if (!err) begin
                  remain_in = seqlen_in;
                  if (last) err = 1'b1;
               end
            end
         end else if (b[7:6] != 2'b10) begin
            err = 1'b1;
         end else begin
            pending_in = shifted;
            remain_in = remain_ff - 2'd1;
            if (remain_in == 2'd0) begin
               if (shifted < least || shifted > 21'h10FFFF ||
                   (shifted >= 21'hD800 && shifted <= 21'hDFFF)) err = 1'b1;
               else begin
                  code_point = shifted;
                  done = 1'b1;
               end
            end else if (last) err = 1'b1;
         end
      end
      reject_in = reject_ff | err;
      count_in = count_ff + CntW'(done);
      emit = done | last;
      rejected = last & reject_in;
      total = (last && !reject_in) ? count_in[10:0] : 11'd0;
      if (last) begin
         pending_in = '0; remain_in = '0; seqlen_in = '0; count_in = '0; reject_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0; remain_ff <= '0; seqlen_ff <= '0;
         count_ff <= '0; reject_ff <= 1'b0;
      end else if (step) begin
         pending_ff <= pending_in; remain_ff <= remain_in; seqlen_ff <= seqlen_in;
         count_ff <= count_in; reject_ff <= reject_in;
      end
   end
endmodule

FILE: hdl/udf_fold.sv
// Fold stage: result register holding the folded beat, with valid/ready to the sink.
// Depends on udf_pkg (fold function, rsp_type).
module udf_fold (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             done,
   input  logic [20:0]      code_point,
   input  logic             rejected,
   input  logic [10:0]      total,
   input  logic             last,
   input  logic             rsp_ready,
   output logic             rsp_valid,
   output udf_pkg::rsp_type rsp
);
   logic             valid_ff, valid_in;
   udf_pkg::rsp_type data_ff, data_in;

   always_comb begin
      data_in.folded_code_point = done ? udf_pkg::fold(code_point) : 21'd0;
      data_in.has_code_point = done;
      data_in.text_end = last;
      data_in.text_rejected = rejected;
      data_in.code_point_total = total;
      valid_in = load | (valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (load) data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp = data_ff;
endmodule

FILE: hdl/utf8_decode_and_fold.sv
// UTF-8 decoder with character folding, one byte per beat.
// Each result beat is registered; input stalls while a result beat waits unaccepted.
// Throughput: one byte per cycle unless stalled; refilled in the cycle the result is taken.
// Reset (synchronous, active high) clears the decode state and result valid, and sets
// max_code_points to 1024.
module utf8_decode_and_fold #(
   parameter int unsigned MAX_TEXT_CODE_POINTS = udf_pkg::MaxTextCodePoints
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  udf_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output udf_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [10:0]      csr_data
);
   logic [10:0] max_cp_ff;
   logic        step, emit, done, rejected;
   logic [20:0] code_point;
   logic [10:0] total;

   assign req_ready = ~rsp_valid | rsp_ready;
   assign step = req_valid & req_ready;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) max_cp_ff <= udf_pkg::MaxCodePointsReset;
      else if (csr_valid) max_cp_ff <= csr_data;
   end

   udf_decode #(.MAX_TEXT_CODE_POINTS(MAX_TEXT_CODE_POINTS)) u_decode (
      .clock(clock), .reset(reset), .step(step), .req(req_data), .limit_reg(max_cp_ff),
      .emit(emit), .done(done), .code_point(code_point), .rejected(rejected), .total(total)
   );

   udf_fold u_fold (
      .clock(clock), .reset(reset), .load(step & emit), .done(done),
      .code_point(code_point), .rejected(rejected), .total(total),
      .last(req_data.end_of_text), .rsp_ready(rsp_ready), .rsp_valid(rsp_valid),
      .rsp(rsp_data)
   );
endmodule

FILE: hdl/udf_checker.sv
// Port-level checks for utf8_decode_and_fold, bound to the top level.
// Depends on udf_pkg.
module udf_checks (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input udf_pkg::rsp_type rsp_data
);
   a_stall: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result beat changed while stalled");
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready) else $error("input stalled with empty output");
   a_cp_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.has_code_point |-> rsp_data.folded_code_point == 21'd0)
      else $error("code point without flag");
   a_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.text_end |->
      !rsp_data.text_rejected && rsp_data.code_point_total == 11'd0)
      else $error("end fields outside text end");
   a_rej: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.text_rejected |-> rsp_data.code_point_total == 11'd0)
      else $error("total on rejected text");
endmodule

bind utf8_decode_and_fold udf_checks u_udf_checks (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
);
